[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Types, sizes and codes shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int WORD_BITS  = 32;
    localparam int INIT_WORDS = 32;
    localparam int MAX_WORDS  = 1024;

    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int WORD_IDX_W = $clog2(MAX_WORDS);
    localparam int ACT_W      = $clog2(MAX_WORDS + 1);

    // Fixed field widths of the command and result words
    localparam int BLK_W  = 15;
    localparam int CAP_W  = 16;
    localparam int STAT_W = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_DUP   = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd3;

    localparam logic [BLK_W-1:0] COUNT_MAX = {BLK_W{1'b1}};

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic             cmd;
        logic [BLK_W-1:0] block_to_free;
    } t_in_item;

    typedef struct packed {
        logic [BLK_W-1:0]  block_number;
        logic [STAT_W-1:0] status;
        logic [CAP_W-1:0]  high_water_blocks;
        logic [BLK_W-1:0]  free_count;
        logic [CAP_W-1:0]  capacity_blocks;
    } t_out_item;

    // Bitmap memory access: one address, a read or a write per cycle
    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic [WORD_IDX_W-1:0] addr;
        t_word                 wdata;
    } t_mem_req;

    // Index of the lowest set bit; zero for an empty word
    function automatic logic [BIT_IDX_W-1:0] lowest_set(input t_word w);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/bba_bitmap_mem.sv]
// ----------------------------------------------------------------------------
// bba_bitmap_mem
// Free bitmap store: one word per access, registered read data.
// ----------------------------------------------------------------------------
module bba_bitmap_mem
    import bba_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_word    o_rdata
);

    t_word r_mem [MAX_WORDS];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// Command sequencer: clearing pass, first-fit scan, range growth and free.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_item o_result,
    output t_mem_req  o_mem_req,
    input  t_word     i_rdata
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_A_ISSUE = 3'd2;
    localparam logic [2:0] ST_A_CHECK = 3'd3;
    localparam logic [2:0] ST_F_CHECK = 3'd4;

    logic [2:0]            r_state,   n_state;
    logic [WORD_IDX_W-1:0] r_clr_idx, n_clr_idx;
    logic [BLK_W-1:0]      r_hint,    n_hint;
    logic [ACT_W-1:0]      r_active,  n_active;
    logic [CAP_W-1:0]      r_hw,      n_hw;
    logic [BLK_W-1:0]      r_cnt,     n_cnt;
    logic [ACT_W-1:0]      r_word,    n_word;
    logic [BLK_W-1:0]      r_blk,     n_blk;
    logic                  r_strobe,  n_strobe;
    logic [BLK_W-1:0]      r_res_blk, n_res_blk;
    logic [STAT_W-1:0]     r_status,  n_status;

    logic [CAP_W-1:0]     cap;
    logic [BIT_IDX_W-1:0] ffs_idx;
    logic [BLK_W-1:0]     take_blk;
    logic [CAP_W-1:0]     take_next;
    logic [BIT_IDX_W-1:0] free_bit;
    t_mem_req             req;

    assign cap       = CAP_W'(r_active) << BIT_IDX_W;
    assign ffs_idx   = lowest_set(i_rdata);
    assign take_blk  = BLK_W'({r_word[WORD_IDX_W-1:0], ffs_idx});
    assign take_next = CAP_W'(take_blk) + CAP_W'(1);
    assign free_bit  = r_blk[BIT_IDX_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_hint    = r_hint;
        n_active  = r_active;
        n_hw      = r_hw;
        n_cnt     = r_cnt;
        n_word    = r_word;
        n_blk     = r_blk;
        n_strobe  = 1'b0;
        n_res_blk = r_res_blk;
        n_status  = r_status;
        req       = '0;

        case (r_state)
            ST_CLEAR: begin
                // Block zero stays reserved
                req.wr    = 1'b1;
                req.addr  = r_clr_idx;
                req.wdata = (r_clr_idx == '0) ? ~t_word'(1) : '1;
                n_clr_idx = r_clr_idx + WORD_IDX_W'(1);
                if (r_clr_idx == WORD_IDX_W'(MAX_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_res_blk = '0;
                    if (i_item.cmd == CMD_ALLOC) begin
                        n_word  = ACT_W'(r_hint[BLK_W-1:BIT_IDX_W]);
                        n_state = ST_A_ISSUE;
                    end else if (i_item.block_to_free == '0 ||
                                 CAP_W'(i_item.block_to_free) >= cap) begin
                        n_strobe = 1'b1;
                        n_status = STATUS_RANGE;
                    end else begin
                        req.rd  = 1'b1;
                        req.addr = i_item.block_to_free[BLK_W-1:BIT_IDX_W];
                        n_blk   = i_item.block_to_free;
                        n_state = ST_F_CHECK;
                    end
                end
            end
            ST_A_ISSUE: begin
                if (r_word < r_active) begin
                    req.rd   = 1'b1;
                    req.addr = r_word[WORD_IDX_W-1:0];
                    n_state  = ST_A_CHECK;
                end else if (r_active >= ACT_W'(MAX_WORDS)) begin
                    n_strobe  = 1'b1;
                    n_res_blk = '0;
                    n_status  = STATUS_FULL;
                    n_state   = ST_IDLE;
                end else begin
                    // Grow the range; words above it were never touched and
                    // still hold all ones from the clearing pass
                    if (r_active >= ACT_W'(MAX_WORDS / 2)) begin
                        n_active = ACT_W'(MAX_WORDS);
                    end else begin
                        n_active = r_active << 1;
                    end
                    n_hint = BLK_W'(cap);
                    n_word = r_active;
                end
            end
            ST_A_CHECK: begin
                if (i_rdata != '0) begin
                    req.wr    = 1'b1;
                    req.addr  = r_word[WORD_IDX_W-1:0];
                    req.wdata = i_rdata & ~(t_word'(1) << ffs_idx);
                    n_hint    = take_next[BLK_W-1:0];
                    if (r_hw < take_next) begin
                        n_hw = take_next;
                    end
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - BLK_W'(1);
                    end
                    n_strobe  = 1'b1;
                    n_res_blk = take_blk;
                    n_status  = STATUS_OK;
                    n_state   = ST_IDLE;
                end else begin
                    n_word  = r_word + ACT_W'(1);
                    n_state = ST_A_ISSUE;
                end
            end
            ST_F_CHECK: begin
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
                if (i_rdata[free_bit]) begin
                    n_status = STATUS_DUP;
                end else begin
                    req.wr    = 1'b1;
                    req.addr  = r_blk[BLK_W-1:BIT_IDX_W];
                    req.wdata = i_rdata | (t_word'(1) << free_bit);
                    if (r_hint > r_blk) begin
                        n_hint = r_blk;
                    end
                    if (r_cnt != COUNT_MAX) begin
                        n_cnt = r_cnt + BLK_W'(1);
                    end
                    n_status = STATUS_OK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_hint    <= '0;
            r_active  <= ACT_W'(INIT_WORDS);
            r_hw      <= '0;
            r_cnt     <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_hint    <= n_hint;
            r_active  <= n_active;
            r_hw      <= n_hw;
            r_cnt     <= n_cnt;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_blk     <= n_blk;
        r_res_blk <= n_res_blk;
        r_status  <= n_status;
    end

    assign o_mem_req = req;
    assign o_busy    = (r_state != ST_IDLE);
    assign o_strobe  = r_strobe;

    // State after the command that raised the strobe
    assign o_result.block_number      = r_res_blk;
    assign o_result.status            = r_status;
    assign o_result.high_water_blocks = r_hw;
    assign o_result.free_count        = r_cnt;
    assign o_result.capacity_blocks   = cap;

`ifndef SYNTHESIS
    a_mem_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.rd && req.wr))
        else $error("bitmap read and write in the same cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == ST_IDLE))
        else $error("result shown while a command is still running");

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active <= ACT_W'(MAX_WORDS)) && (r_active >= ACT_W'(INIT_WORDS)))
        else $error("active range out of bounds");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == ST_IDLE) |=> (r_state != ST_IDLE) || r_strobe)
        else $error("accepted command neither started nor answered");

    a_range_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |=> (r_active >= $past(r_active)))
        else $error("active range shrank");
`endif

endmodule

[rtl/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a free bitmap held in a synchronous memory.
// ----------------------------------------------------------------------------
// After reset busy stays high for a clearing pass over all MAX_WORDS (1024)
// words while the bitmap is set to all free (block 0 reserved). A command is
// taken when start is high and busy is low; its result appears on o_result
// for one cycle with o_strobe high, and the receiver cannot hold it off. A
// free that is reserved or out of range answers in the cycle after
// acceptance; any other free reads its word, and F_CHECK tests the bit,
// writes the word back unless the block was already free, and raises the
// strobe. An allocate scans words from the word of the hint: A_ISSUE reads a
// word, then A_CHECK finds its lowest set bit, writes it back and raises the
// strobe on a hit; at the top of the range the range doubles, up to
// MAX_WORDS, and the scan goes on. An allocate that finds the store full has
// walked every word from the hint to the last of the MAX_WORDS words. busy
// falls in the strobe cycle, so the next command may be given then.
module bitmap_block_allocator
    import bba_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_mem_req mem_req;
    t_word    mem_rdata;

    bba_bitmap_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .o_busy    (busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .o_mem_req (mem_req),
        .i_rdata   (mem_rdata)
    );

endmodule
